### rtl/sample_fifo_packet_framer_macros.svh
// Assertion macros for the sample FIFO packet framer checker.
// Depends on nothing; included by the checker file.
`ifndef SAMPLE_FIFO_PACKET_FRAMER_MACROS_SVH
`define SAMPLE_FIFO_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SFPF_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("sfpf assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SFPF_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("sfpf assertion failed");

`endif

### rtl/sfpf_pkg.sv
// Package for the sample FIFO packet framer: field widths, markers, byte kinds.
// Depends on nothing; used by the interfaces, the top level and the checker.
`default_nettype none

package sfpf_pkg;

    localparam int FIFO_DEPTH_DEF = 128;

    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 16;

    localparam logic [LEN_W-1:0] PACKET_LENGTH_RST = 16'd1024;

    localparam logic [BYTE_W-1:0] MARK_OPEN  = 8'h5C;
    localparam logic [BYTE_W-1:0] MARK_CLOSE = 8'hC5;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

endpackage

`default_nettype wire

### rtl/sfpf_stream_if.sv
// Valid/ready channel interfaces for the framer's input items and output bytes.
// Depends on sfpf_pkg for field widths.
`default_nettype none

interface sfpf_in_if;
    import sfpf_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface sfpf_out_if;
    import sfpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic [KIND_W-1:0] byte_kind;
    logic              last;

    modport source (output valid, output tx_byte, output byte_kind, output last, input ready);
    modport sink   (input valid, input tx_byte, input byte_kind, input last, output ready);
endinterface

`default_nettype wire

### rtl/sample_fifo_packet_framer.sv
// Sample FIFO with packet framer. An accepted item is held in the input register until
// it is processed; its bytes are then registered in the result buffer, which drives the
// result channel. Samples are taken one per cycle unless a tick waits there for the
// two-entry result buffer, which drains one byte per cycle while result.ready is high.
// Reset (rst_n, async, low) clears pointers, phase, count and buffers and sets
// packet_length to 1024; the sample store is not cleared and needs no sweep.
`default_nettype none

module sample_fifo_packet_framer #(
    parameter int FIFO_DEPTH = sfpf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    sfpf_in_if.sink          item,
    sfpf_out_if.source       result
);
    import sfpf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic REG_PACKET_LENGTH = 1'b0;

    typedef enum logic [1:0] {PH_START, PH_SIZE, PH_DATA, PH_END} phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic [KIND_W-1:0] byte_kind;
        logic              last;
    } res_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // State registers
    logic                in_valid_reg;
    logic                in_op_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    sent_reg, sent_next;
    logic [LEN_W-1:0]    plen_reg;
    logic [1:0]          buf_cnt_reg;
    res_t                buf0_reg, buf1_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];

    logic       out_fire, buf_free, can_proc, tick_proc;
    logic       fifo_empty, fifo_full, mem_we, cfg_wr;
    res_t       r0, r1;
    logic [1:0] r_cnt;

    // Handshakes
    assign out_fire     = result.valid && result.ready;
    assign buf_free     = (buf_cnt_reg == 2'd0) || ((buf_cnt_reg == 2'd1) && out_fire);
    assign can_proc     = in_valid_reg && (!in_op_reg || buf_free);
    assign tick_proc    = can_proc && in_op_reg;
    assign item.ready   = !in_valid_reg || can_proc;
    assign result.valid = (buf_cnt_reg != 2'd0);
    assign result.tx_byte   = buf0_reg.tx_byte;
    assign result.byte_kind = buf0_reg.byte_kind;
    assign result.last      = buf0_reg.last;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PACKET_LENGTH);
    assign prdata = (paddr[2] == REG_PACKET_LENGTH) ? {16'd0, plen_reg} : 32'd0;

    assign fifo_empty = (rd_ptr_reg == wr_ptr_reg);
    assign fifo_full  = (rd_ptr_reg == ptr_inc(wr_ptr_reg));

    // Process the item held in the input register
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        phase_next  = phase_reg;
        sent_next   = sent_reg;
        mem_we      = 1'b0;
        r0          = '0;
        r1          = '0;
        r_cnt       = 2'd0;
        if (can_proc && !in_op_reg)
        begin
            if (!fifo_full)
            begin
                mem_we      = 1'b1;
                wr_ptr_next = ptr_inc(wr_ptr_reg);
            end
        end
        else if (tick_proc)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    r0         = '{MARK_OPEN, KIND_START, 1'b1};
                    r_cnt      = 2'd1;
                    sent_next  = '0;
                    phase_next = PH_SIZE;
                end
                PH_SIZE:
                begin
                    r0         = '{plen_reg[7:0], KIND_SIZE, 1'b0};
                    r1         = '{plen_reg[15:8], KIND_SIZE, 1'b1};
                    r_cnt      = 2'd2;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (sent_reg < plen_reg)
                    begin
                        if (!fifo_empty)
                        begin
                            r0          = '{rd_data_reg[7:0], KIND_DATA, 1'b0};
                            r1          = '{{6'd0, rd_data_reg[9:8]}, KIND_DATA, 1'b1};
                            r_cnt       = 2'd2;
                            rd_ptr_next = ptr_inc(rd_ptr_reg);
                            sent_next   = sent_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sent_next  = '0;
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    r0         = '{MARK_CLOSE, KIND_END, 1'b1};
                    r_cnt      = 2'd1;
                    phase_next = PH_START;
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    // Sample store: write on push, registered read of the next head with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[wr_ptr_reg] <= in_sample_reg;
        end
        if (mem_we && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_data_reg <= in_sample_reg;
        end
        else
        begin
            rd_data_reg <= fifo_mem[rd_ptr_next];
        end
    end

    // Hold state, input register and result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_op_reg     <= 1'b0;
            in_sample_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            phase_reg     <= PH_START;
            sent_reg      <= '0;
            plen_reg      <= PACKET_LENGTH_RST;
            buf_cnt_reg   <= 2'd0;
            buf0_reg      <= '0;
            buf1_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg  <= item.valid;
                in_op_reg     <= item.op;
                in_sample_reg <= item.sample;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            phase_reg  <= phase_next;
            sent_reg   <= sent_next;
            if (cfg_wr)
            begin
                plen_reg <= pwdata[LEN_W-1:0];
            end
            // Load fresh bytes, or advance the buffer by one sent byte
            if (tick_proc)
            begin
                buf0_reg    <= r0;
                buf1_reg    <= r1;
                buf_cnt_reg <= r_cnt;
            end
            else if (out_fire)
            begin
                buf0_reg    <= buf1_reg;
                buf_cnt_reg <= buf_cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sfpf_checker.sv
// Port-level checker for the sample FIFO packet framer, bound to the top level.
// Depends on sfpf_pkg and sample_fifo_packet_framer_macros.svh.
`default_nettype none
`include "sample_fifo_packet_framer_macros.svh"

module sfpf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [sfpf_pkg::BYTE_W-1:0] out_tx_byte,
    input wire logic [sfpf_pkg::KIND_W-1:0] out_byte_kind,
    input wire logic                       out_last
);
    import sfpf_pkg::*;

    // Hold a stalled transaction
    `SFPF_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SFPF_ASSERT_NEXT(a_payload_hold, clk, rst_n, out_valid && !out_ready, $stable(out_tx_byte) && $stable(out_byte_kind) && $stable(out_last))

    // Start marker is a lone byte with the fixed value
    `SFPF_ASSERT_NOW(a_start_marker, clk, rst_n, out_valid && (out_byte_kind == KIND_START), out_last && (out_tx_byte == MARK_OPEN))

    // High data byte carries only the two top sample bits
    `SFPF_ASSERT_NOW(a_data_high, clk, rst_n, out_valid && (out_byte_kind == KIND_DATA) && out_last, out_tx_byte[7:2] == 6'd0)

endmodule

bind sample_fifo_packet_framer sfpf_checker u_sfpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_tx_byte   (result.tx_byte),
    .out_byte_kind (result.byte_kind),
    .out_last      (result.last)
);

`default_nettype wire
